// ===== rtl/core/lhc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhc_pkg
// shared types and constants for the lz77 history copy unit
// ----------------------------------------------------------------------------
package lhc_pkg;

    localparam int WIN_AW      = 15;
    localparam int WINDOW_SIZE = 1 << WIN_AW;
    localparam int MAX_COPY    = 64;
    localparam int LEN_W       = 7;
    localparam int DIST_W      = 16;
    localparam int DIST_CMP_W  = WIN_AW + 2;

    localparam logic [7:0] FILL_BYTE = 8'h3F;

    localparam logic CMD_LITERAL = 1'b0;
    localparam logic CMD_COPY    = 1'b1;

    typedef struct packed {
        logic              cmd;
        logic [7:0]        literal;
        logic [LEN_W-1:0]  copy_length;
        logic [DIST_W-1:0] distance;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } out_item_t;

    typedef enum logic {
        ST_IDLE,
        ST_COPY
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic lit_accept;
        logic copy_start;
        logic emit;
        logic issue_next;
    } lhc_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
        logic len_zero;
        logic more;
    } lhc_status_t;

endpackage

// ===== rtl/core/lhc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhc_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module lhc_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 32768
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        // read data holds while no read is issued
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/lhc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhc_ctrl
// request sequencing: literal append, copy start and per byte emission
// ----------------------------------------------------------------------------
module lhc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_cmd,
    output logic                in_ready,
    input  lhc_pkg::lhc_status_t status,
    output lhc_pkg::lhc_cmd_t    cmd
);

    import lhc_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = status.out_free;
                if (in_valid && status.out_free)
                begin
                    if (in_cmd == CMD_LITERAL)
                    begin
                        cmd.lit_accept = 1'b1;
                    end
                    else if (!status.len_zero)
                    begin
                        cmd.copy_start = 1'b1;
                        state_next     = ST_COPY;
                    end
                end
            end
            ST_COPY:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.more)
                    begin
                        cmd.issue_next = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/lhc_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhc_datapath
// history ring, write pointer, copy counters and result register
// ----------------------------------------------------------------------------
module lhc_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lhc_pkg::in_item_t    in_data,
    input  lhc_pkg::lhc_cmd_t    cmd,
    output lhc_pkg::lhc_status_t status,
    output logic                 out_valid,
    input  logic                 out_ready,
    output lhc_pkg::out_item_t   out_data
);

    import lhc_pkg::*;

    logic [WIN_AW-1:0] wp_reg;
    logic [WIN_AW-1:0] wp_inc;
    logic              wrapped_reg;
    logic [LEN_W-1:0]  cnt_reg;
    logic [WIN_AW-1:0] dist_reg;
    logic              bad_reg;
    logic              byp_reg;
    logic [7:0]        prev_byte_reg;
    logic              out_valid_reg;
    out_item_t         out_reg;

    logic [LEN_W-1:0]      len_sat;
    logic [DIST_CMP_W-1:0] dist_eff;
    logic                  bad;
    logic [7:0]            copy_byte;
    logic                  wr_en;
    logic [7:0]            wr_data;
    logic                  rd_en;
    logic [WIN_AW-1:0]     rd_addr;
    logic [7:0]            rd_data;

    assign wp_inc  = wp_reg + 1'b1;
    assign len_sat = (in_data.copy_length > LEN_W'(MAX_COPY)) ? LEN_W'(MAX_COPY)
                                                               : in_data.copy_length;

    // zero distance means a whole window back
    assign dist_eff = (in_data.distance == '0) ? DIST_CMP_W'(WINDOW_SIZE)
                                               : DIST_CMP_W'(in_data.distance);
    assign bad = (dist_eff > DIST_CMP_W'(WINDOW_SIZE))
              || (!wrapped_reg && (dist_eff > DIST_CMP_W'(wp_reg)));

    // distance one reads the byte being written in the same cycle
    assign copy_byte = bad_reg ? FILL_BYTE : (byp_reg ? prev_byte_reg : rd_data);

    assign wr_en   = cmd.lit_accept | cmd.emit;
    assign wr_data = cmd.lit_accept ? in_data.literal : copy_byte;
    assign rd_en   = cmd.copy_start | cmd.issue_next;
    assign rd_addr = cmd.copy_start ? (wp_reg - in_data.distance[WIN_AW-1:0])
                                    : (wp_inc - dist_reg);

    lhc_ram #(
        .DATA_W (8),
        .DEPTH  (WINDOW_SIZE)
    ) u_hist_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wp_reg),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg        <= '0;
            wrapped_reg   <= 1'b0;
            cnt_reg       <= '0;
            bad_reg       <= 1'b0;
            byp_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                wp_reg <= wp_inc;
                if (wp_reg == WIN_AW'(WINDOW_SIZE - 1))
                begin
                    wrapped_reg <= 1'b1;
                end
            end
            if (cmd.copy_start)
            begin
                cnt_reg <= len_sat;
                bad_reg <= bad;
                byp_reg <= 1'b0;
            end
            else if (cmd.emit)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                byp_reg <= cmd.issue_next && (dist_reg == WIN_AW'(1));
            end
            if (wr_en)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.copy_start)
        begin
            dist_reg <= in_data.distance[WIN_AW-1:0];
        end
        if (cmd.emit)
        begin
            prev_byte_reg <= copy_byte;
        end
        if (wr_en)
        begin
            out_reg.out_byte <= wr_data;
            out_reg.last     <= cmd.lit_accept || (cnt_reg == LEN_W'(1));
        end
    end

    assign status.out_free = !out_valid_reg || out_ready;
    assign status.len_zero = (in_data.copy_length == '0);
    assign status.more     = (cnt_reg > LEN_W'(1));

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ===== rtl/core/lz77_history_copy_unit.sv =====
`timescale 1ns / 1ps
// a literal is written to the output register when its request is taken; a
// copy first reads the history ram into the ram read register, then writes
// each byte to the output register once the output is free, one byte per
// cycle while the output is not stalled, through the single read port of the history ram
// reset clears the write pointer, the wrap flag, the sequencer and the output
// valid; the history ram is not cleared and holds no data until written
// ----------------------------------------------------------------------------
// lz77_history_copy_unit
// inflate side lz77 history window with literal append and back reference copy
// ----------------------------------------------------------------------------
module lz77_history_copy_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  lhc_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output lhc_pkg::out_item_t out_data
);

    import lhc_pkg::*;

    lhc_cmd_t    cmd;
    lhc_status_t status;

    lhc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_cmd   (in_data.cmd),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    lhc_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ===== sim/lz77_history_copy_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz77_history_copy_unit_tb
// self-checking bench for the lz77 history window: literals and back
// references go in under random handshake pressure. A scoreboard keeps its
// own copy of the ring, predicts every decoded byte and compares each one as
// it leaves the block. Directed requests cover the empty window, overlapping
// patterns and oversize copies; random requests cover the rest.
// ----------------------------------------------------------------------------
module lz77_history_copy_unit_tb;

    import lhc_pkg::*;

    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int MAX_REPORTS = 10;
    localparam int SETTLE      = 20;

    // ------------------------------------------------------------------------
    // scoreboard: private ring copy and the queue of predicted bytes
    // ------------------------------------------------------------------------
    class history_scoreboard;
        bit [7:0]    ring [WINDOW_SIZE];
        int unsigned wr_pos;
        bit          wrapped;
        out_item_t   expected_bytes [$];
        int unsigned faults;

        function new();
            wr_pos  = 0;
            wrapped = 1'b0;
            faults  = 0;
        endfunction

        function void append(bit [7:0] b, bit last);
            out_item_t e;
            ring[wr_pos] = b;
            wr_pos++;
            if (wr_pos == WINDOW_SIZE)
            begin
                wr_pos  = 0;
                wrapped = 1'b1;
            end
            e.out_byte = b;
            e.last     = last;
            expected_bytes.insert(expected_bytes.size(), e);
        endfunction

        function void note_request(in_item_t req);
            int unsigned len;
            int unsigned back;
            bit          bad;
            bit [7:0]    b;
            if (req.cmd == CMD_LITERAL)
            begin
                append(req.literal, 1'b1);
                return;
            end
            len  = req.copy_length;
            back = req.distance;
            if (len > MAX_COPY)
                len = MAX_COPY;
            // zero distance points at the oldest slot in the ring
            if (back == 0)
                back = WINDOW_SIZE;
            // judged once per request, before the first byte
            bad = (back > WINDOW_SIZE) || (!wrapped && back > wr_pos);
            for (int i = 0; i < len; i++)
            begin
                if (bad)
                    b = FILL_BYTE;
                else
                    b = ring[(wr_pos + WINDOW_SIZE - back) % WINDOW_SIZE];
                append(b, i == len - 1);
            end
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (expected_bytes.size() == 0)
            begin
                faults++;
                if (faults <= MAX_REPORTS)
                    $display("unexpected byte %02h last %0b", got.out_byte, got.last);
                return;
            end
            want = expected_bytes.pop_front();
            if (got.out_byte !== want.out_byte || got.last !== want.last)
            begin
                faults++;
                if (faults <= MAX_REPORTS)
                    $display("mismatch: expected byte %02h last %0b, got byte %02h last %0b",
                             want.out_byte, want.last, got.out_byte, got.last);
            end
        endfunction

        function int unsigned pending();
            return expected_bytes.size();
        endfunction

        function int unsigned depth();
            return wrapped ? WINDOW_SIZE : wr_pos;
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;

    history_scoreboard sb = new();
    bit                idle_on;
    int unsigned       cycles;

    lz77_history_copy_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // fields the command does not use carry noise
    function automatic in_item_t make_request(logic cmd, int unsigned lit,
                                              int unsigned len, int unsigned back);
        in_item_t r;
        r = $urandom;
        r.cmd = cmd;
        if (cmd == CMD_LITERAL)
            r.literal = 8'(lit);
        else
        begin
            r.copy_length = LEN_W'(len);
            r.distance    = DIST_W'(back);
        end
        return r;
    endfunction

    function automatic in_item_t random_request();
        in_item_t    r;
        int unsigned d;
        int unsigned pick;
        r = $urandom;
        r.cmd = ($urandom_range(0, 9) < 4) ? CMD_LITERAL : CMD_COPY;
        if (r.cmd == CMD_COPY)
        begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
                r.copy_length = '0;
            else if (pick < 3)
                r.copy_length = LEN_W'($urandom_range(MAX_COPY + 1, 127));
            else
                r.copy_length = LEN_W'($urandom_range(1, MAX_COPY));
            d    = sb.depth();
            pick = $urandom_range(0, 19);
            if (pick < 8 && d > 0)
                r.distance = DIST_W'($urandom_range(1, d > 16 ? 16 : d));
            else if (pick < 14 && d > 0)
                r.distance = DIST_W'($urandom_range(1, d));
            else if (pick < 16)
                r.distance = '0;
            else if (pick < 18)
                r.distance = DIST_W'($urandom_range(d + 1, 65535));
            else
                r.distance = DIST_W'($urandom);
        end
        return r;
    endfunction

    task automatic send_request(input in_item_t req);
        int unsigned gap;
        gap = idle_on ? $urandom_range(0, 8) : 0;
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            in_data  <= $urandom;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_request(req);
    endtask

    // hold off new requests until every predicted byte has left the block
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic run_random(input int unsigned n);
        for (int i = 0; i < n; i++)
        begin
            if (i % 40 == 0)
                idle_on = ($urandom_range(0, 3) != 0);
            send_request(random_request());
        end
    endtask

    // result side: random stall after each accepted byte while idle_on is set
    initial
    begin : result_sink
        int unsigned stall;
        stall = 0;
        forever
        begin
            @(negedge clk);
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                stall--;
            end
            else
                out_ready <= 1'b1;
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                sb.check_result(out_data);
                stall = idle_on ? $urandom_range(0, 8) : 0;
            end
        end
    end

    initial
    begin : stimulus
        in_valid  = 1'b0;
        in_data   = '0;
        out_ready = 1'b0;
        rst_n     = 1'b0;
        idle_on   = 1'b1;
        cycles    = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty window: references before any literal are out of range
        send_request(make_request(CMD_COPY, 0, 3, 1));
        send_request(make_request(CMD_COPY, 0, 1, 0));
        send_request(make_request(CMD_LITERAL, 8'h00, 0, 0));
        send_request(make_request(CMD_LITERAL, 8'hFF, 0, 0));
        send_request(make_request(CMD_LITERAL, 8'hA5, 0, 0));
        send_request(make_request(CMD_LITERAL, 8'h5A, 0, 0));
        send_request(make_request(CMD_COPY, 0, 0, 1));
        send_request(make_request(CMD_COPY, 0, 1, 1));
        // overlapping copies repeat a short pattern; the rest probe distances at and past the window
        send_request(make_request(CMD_COPY, 0, 64, 3));
        send_request(make_request(CMD_COPY, 0, 127, 2));
        send_request(make_request(CMD_COPY, 0, 65, 65535));
        send_request(make_request(CMD_COPY, 0, 2, WINDOW_SIZE + 1));
        send_request(make_request(CMD_COPY, 0, 2, WINDOW_SIZE));
        send_request(make_request(CMD_COPY, 0, 4, sb.wr_pos));
        send_request(make_request(CMD_COPY, 0, 4, sb.wr_pos + 1));
        send_request(make_request(CMD_LITERAL, 8'h80, 0, 0));
        send_request(make_request(CMD_LITERAL, 8'h01, 0, 0));
        drain();

        run_random(125);
        drain();

        run_random(125);

        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        if (sb.faults == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== lz77_history_copy_unit.f =====
rtl/core/lhc_pkg.sv
rtl/core/lhc_ram.sv
rtl/core/lhc_ctrl.sv
rtl/core/lhc_datapath.sv
rtl/core/lz77_history_copy_unit.sv
sim/lz77_history_copy_unit_tb.sv
